### sv/swipe_pkg.sv
// Shared types, codes and register defaults for the swipe gesture recogniser.
package swipe_pkg;

	// Default widths of the parameterised ports
	localparam int COORD_BITS_DEF = 16;
	localparam int TIMER_BITS_DEF = 16;

	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [2:0] {
		KIND_BEGIN  = 3'd0,
		KIND_MOVE   = 3'd1,
		KIND_END    = 3'd2,
		KIND_CANCEL = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE       = 2'd0,
		ST_POSSIBLE   = 2'd1,
		ST_FAILED     = 2'd2,
		ST_RECOGNISED = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		DIR_RIGHT = 2'd0,
		DIR_LEFT  = 2'd1,
		DIR_UP    = 2'd2,
		DIR_DOWN  = 2'd3
	} dir_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_X_SWIPE_MIN   = 3'd0,
		CFG_Y_SWIPE_MIN   = 3'd1,
		CFG_X_TOLERANCE   = 3'd2,
		CFG_Y_TOLERANCE   = 3'd3,
		CFG_TIMEOUT_TICKS = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [14:0] x_swipe_min;
		logic [14:0] y_swipe_min;
		logic [14:0] x_tolerance;
		logic [14:0] y_tolerance;
		logic [15:0] timeout_ticks;
	} cfg_t;

	localparam logic [14:0] X_SWIPE_MIN_RST   = 15'd60;
	localparam logic [14:0] Y_SWIPE_MIN_RST   = 15'd60;
	localparam logic [14:0] X_TOLERANCE_RST   = 15'd40;
	localparam logic [14:0] Y_TOLERANCE_RST   = 15'd40;
	localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd1000;

	typedef struct packed {
		logic hit;
		dir_t dir;
	} cls_t;

	typedef struct packed {
		status_t status;
		dir_t    direction;
		logic    notify;
	} res_t;

endpackage

### sv/swipe_classify.sv
// Move classifier: delta from the last point tested against thresholds and tolerances.
module swipe_classify import swipe_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] last_x,
	input  logic signed [COORD_BITS-1:0] last_y,
	input  cfg_t                         cfg,
	output cls_t                         cls
);

	// wide enough for a coordinate difference and a negated 15-bit threshold
	localparam int DW = (((COORD_BITS + 1) > 16) ? (COORD_BITS + 1) : 16) + 1;

	logic signed [DW-1:0] dx, dy, adx, ady;
	logic signed [DW-1:0] xm, ym, xt, yt;
	logic                 x_ok, y_ok;

	always_comb begin
		dx  = DW'(pos_x) - DW'(last_x);
		dy  = DW'(pos_y) - DW'(last_y);
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		xm  = signed'(DW'(cfg.x_swipe_min));
		ym  = signed'(DW'(cfg.y_swipe_min));
		xt  = signed'(DW'(cfg.x_tolerance));
		yt  = signed'(DW'(cfg.y_tolerance));
		y_ok = ady < yt;
		x_ok = adx < xt;

		// right, then left, then up, then down
		cls.hit = 1'b1;
		if (dx > xm && y_ok) begin
			cls.dir = DIR_RIGHT;
		end else if (dx < -xm && y_ok) begin
			cls.dir = DIR_LEFT;
		end else if (x_ok && dy > ym) begin
			cls.dir = DIR_UP;
		end else if (x_ok && dy < -ym) begin
			cls.dir = DIR_DOWN;
		end else begin
			cls.hit = 1'b0;
			cls.dir = DIR_RIGHT;
		end
	end

endmodule

### sv/swipe_state.sv
// Gesture state: tracked touch, last point, status, direction and timeout counter.
module swipe_state import swipe_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         step,
	input  logic [2:0]                   kind,
	input  logic [3:0]                   touch_id,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  cfg_t                         cfg,
	output res_t                         res
);

	status_t                      status_q, status_d;
	dir_t                         dir_q, dir_d;
	logic                         tracking_q, tracking_d;
	logic [3:0]                   id_q, id_d;
	logic signed [COORD_BITS-1:0] last_x_q, last_x_d, last_y_q, last_y_d;
	logic [TIMER_BITS-1:0]        timer_q, timer_d;
	logic                         mine, notify;
	cls_t                         cls;

	swipe_classify #(.COORD_BITS(COORD_BITS)) u_classify (
		.pos_x  (pos_x),
		.pos_y  (pos_y),
		.last_x (last_x_q),
		.last_y (last_y_q),
		.cfg    (cfg),
		.cls    (cls)
	);

	always_comb begin
		status_d   = status_q;
		dir_d      = dir_q;
		tracking_d = tracking_q;
		id_d       = id_q;
		last_x_d   = last_x_q;
		last_y_d   = last_y_q;
		timer_d    = timer_q;
		notify     = 1'b0;
		mine       = tracking_q && (touch_id == id_q);
		case (kind)
			KIND_BEGIN: begin
				if (!tracking_q) begin
					status_d   = ST_POSSIBLE;
					timer_d    = TIMER_BITS'(cfg.timeout_ticks);
					tracking_d = 1'b1;
					id_d       = touch_id;
					last_x_d   = pos_x;
					last_y_d   = pos_y;
				end else begin
					// second finger: fail, keep the tracked one
					status_d = ST_FAILED;
					notify   = 1'b1;
				end
			end
			KIND_MOVE: begin
				if (status_q == ST_POSSIBLE && mine) begin
					if (cls.hit) begin
						status_d = ST_RECOGNISED;
						dir_d    = cls.dir;
						notify   = 1'b1;
					end
					last_x_d = pos_x;
					last_y_d = pos_y;
				end
			end
			KIND_END: begin
				if (mine) begin
					tracking_d = 1'b0;
				end
			end
			KIND_CANCEL: begin
				status_d = ST_FAILED;
				if (mine) begin
					tracking_d = 1'b0;
				end
			end
			KIND_TICK: begin
				if (timer_q != '0) begin
					timer_d = timer_q - TIMER_BITS'(1);
					if (timer_q == TIMER_BITS'(1) && status_q == ST_POSSIBLE) begin
						status_d = ST_FAILED;
					end
				end
			end
			default: begin
			end
		endcase
		res.status    = status_d;
		res.direction = dir_d;
		res.notify    = notify;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q   <= ST_IDLE;
			dir_q      <= DIR_RIGHT;
			tracking_q <= 1'b0;
			id_q       <= '0;
			last_x_q   <= '0;
			last_y_q   <= '0;
			timer_q    <= '0;
		end else if (step) begin
			status_q   <= status_d;
			dir_q      <= dir_d;
			tracking_q <= tracking_d;
			id_q       <= id_d;
			last_x_q   <= last_x_d;
			last_y_q   <= last_y_d;
			timer_q    <= timer_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_tick_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_TICK && timer_q != '0 |=> timer_q == $past(timer_q) - TIMER_BITS'(1))
		else $error("timer did not count down on a tick");
	a_begin_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_BEGIN |=> tracking_q)
		else $error("begin left no touch tracked");
	a_move_needs_possible: assert property (@(posedge clk) disable iff (!arst_n)
		step && kind == KIND_MOVE && status_q != ST_POSSIBLE |=> status_q == $past(status_q))
		else $error("move changed status outside possible");
	a_notify_status: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.notify |-> res.status == ST_FAILED || res.status == ST_RECOGNISED)
		else $error("notify with neither failed nor recognised status");
`endif

endmodule

### sv/swipe_gesture_recognizer.sv
// Swipe gesture recogniser top level: config registers, input and result registers.
//
// Usage:
//   Event channel (evt_valid/evt_ready) carries one touch event or timer tick per
//   word: kind, touch_id, pos_x, pos_y. Result channel (res_valid/res_ready) returns
//   exactly one word per event: gesture_status, direction and notify.
//   Configuration is written through cfg_we/cfg_index/cfg_data while no event is
//   in flight; writes take effect at the next edge, indexes beyond the list are
//   ignored.
//   Order: an accepted event is held in the input register, is classified and
//   updates the gesture state as it moves into the result register, which offers
//   its result until taken. Throughput: one event per cycle unless results stall;
//   the state update and move classification are one subtract-and-compare pass
//   between the input and result registers.
//   Reset: thresholds return to their defaults, status idle, no touch tracked,
//   timer unarmed, both registers empty.
//   Stall: a result not taken holds in the result register; the input register
//   still advances while the result register is free, and evt_ready falls only
//   when both hold a word.
module swipe_gesture_recognizer import swipe_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int TIMER_BITS = TIMER_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  logic                         evt_valid,
	output logic                         evt_ready,
	input  logic [2:0]                   kind,
	input  logic [3:0]                   touch_id,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic [1:0]                   gesture_status,
	output logic [1:0]                   direction,
	output logic                         notify
);

	cfg_t                         cfg_q;
	logic                         valid_s1;
	logic [2:0]                   kind_s1;
	logic [3:0]                   id_s1;
	logic signed [COORD_BITS-1:0] pos_x_s1, pos_y_s1;
	logic                         advance;
	res_t                         res_d, res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_swipe_min   <= X_SWIPE_MIN_RST;
			cfg_q.y_swipe_min   <= Y_SWIPE_MIN_RST;
			cfg_q.x_tolerance   <= X_TOLERANCE_RST;
			cfg_q.y_tolerance   <= Y_TOLERANCE_RST;
			cfg_q.timeout_ticks <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_X_SWIPE_MIN:   cfg_q.x_swipe_min   <= cfg_data[14:0];
				CFG_Y_SWIPE_MIN:   cfg_q.y_swipe_min   <= cfg_data[14:0];
				CFG_X_TOLERANCE:   cfg_q.x_tolerance   <= cfg_data[14:0];
				CFG_Y_TOLERANCE:   cfg_q.y_tolerance   <= cfg_data[14:0];
				CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance   = valid_s1 && (!res_valid || res_ready);
	assign evt_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			res_valid <= 1'b0;
		end else begin
			if (evt_ready) begin
				valid_s1 <= evt_valid;
			end
			if (advance) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
		end
	end

	// payload registers: input loads on accept, result on advance, both hold otherwise
	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready) begin
			kind_s1  <= kind;
			id_s1    <= touch_id;
			pos_x_s1 <= pos_x;
			pos_y_s1 <= pos_y;
		end
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	swipe_state #(
		.COORD_BITS (COORD_BITS),
		.TIMER_BITS (TIMER_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.kind     (kind_s1),
		.touch_id (id_s1),
		.pos_x    (pos_x_s1),
		.pos_y    (pos_y_s1),
		.cfg      (cfg_q),
		.res      (res_d)
	);

	assign gesture_status = res_s2.status;
	assign direction      = res_s2.direction;
	assign notify         = res_s2.notify;

endmodule
